// File: rtl/uxr_pkg.sv
// ----------------------------------------------------------------------------
// uxr_pkg: shared types and constants for the serial port ring buffers
// Operation codes, ring control and status groups, and default sizes.
// ----------------------------------------------------------------------------
package uxr_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int BYTE_W    = 8;
  localparam int LEVEL_W   = 4;

  typedef enum logic [2:0] {
    FN_TX_PUSH  = 3'd0,
    FN_TX_POP   = 3'd1,
    FN_RX_PUSH  = 3'd2,
    FN_RX_POP   = 3'd3,
    FN_RX_FLUSH = 3'd4,
    FN_TX_FLUSH = 3'd5
  } func_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } ring_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic low;    // at most one byte held
  } ring_stat_t;

endpackage

// File: rtl/uxr_ring.sv
// ----------------------------------------------------------------------------
// uxr_ring: one byte ring buffer
// Pointers, fill count and a byte store with a registered read port. A push
// into a full ring overwrites the oldest byte; the caller gates pops on empty.
// ----------------------------------------------------------------------------
module uxr_ring
  import uxr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ring_ctl_t           ctl,
  input  logic [BYTE_W-1:0]   wr_data,
  output logic [BYTE_W-1:0]   rd_data,
  output ring_stat_t          stat,
  output logic [LEVEL_W-1:0]  level_next
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [BYTE_W-1:0] mem [DEPTH];

  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic [FILL_W+LEVEL_W-1:0] fill_ext;

  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p);
    step_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    stat.full  = (fill == FILL_W'(DEPTH));
    stat.empty = (fill == '0);
    stat.low   = (fill <= FILL_W'(1));
  end

  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    fill_next   = fill;
    if (ctl.flush) begin
      rd_ptr_next = '0;
      wr_ptr_next = '0;
      fill_next   = '0;
    end else if (ctl.push) begin
      wr_ptr_next = step_ptr(wr_ptr);
      if (stat.full) begin
        rd_ptr_next = step_ptr(rd_ptr);
      end else begin
        fill_next = fill + FILL_W'(1);
      end
    end else if (ctl.pop) begin
      rd_ptr_next = step_ptr(rd_ptr);
      fill_next   = fill - FILL_W'(1);
    end
  end

  // Levels beyond four bits wrap, as the result field is four bits wide.
  assign fill_ext   = {{LEVEL_W{1'b0}}, fill_next};
  assign level_next = fill_ext[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      fill   <= fill_next;
    end
  end

  // A pop only reads entries written by earlier words, so no bypass is needed.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr] <= wr_data;
    end
    if (ctl.pop) begin
      rd_data <= mem[rd_ptr];
    end
  end

endmodule

// File: rtl/uart_tx_rx_ring_buffers.sv
// ----------------------------------------------------------------------------
// uart_tx_rx_ring_buffers: transmit and receive byte buffers for a serial port
// Decodes one operation per word and reports flags and levels for each.
// ----------------------------------------------------------------------------
// Every input word produces exactly one result word. A word is accepted in
// every cycle while the output side keeps up. On acceptance the ring
// pointers are updated and the store is read into its read register; then
// the output register is loaded once the output side can take the word.
// Throughput is set by the single store access per word, one per cycle
// while the output side keeps up. A transmit push into a full buffer is
// refused (push_accepted low) and leaves everything unchanged; a received
// byte is always stored and drops the oldest one when the receive buffer is
// full. Popped bytes read as zero when nothing was popped. Codes six and
// seven do nothing and report the current levels.
module uart_tx_rx_ring_buffers
  import uxr_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         func,
  input  logic [BYTE_W-1:0]  data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               tx_out_valid,
  output logic [BYTE_W-1:0]  tx_out_byte,
  output logic               rx_got,
  output logic [BYTE_W-1:0]  rx_out_byte,
  output logic               push_accepted,
  output logic               rx_dropped_oldest,
  output logic               tx_irq_enable,
  output logic [LEVEL_W-1:0] tx_level,
  output logic [LEVEL_W-1:0] rx_level
);

  ring_ctl_t  tx_ctl, rx_ctl;
  ring_stat_t tx_stat, rx_stat;
  logic [BYTE_W-1:0]  tx_rd, rx_rd;
  logic [LEVEL_W-1:0] tx_lvl_next, rx_lvl_next;

  logic acc, s1_adv;
  logic irq_on, irq_next;
  logic f_txv, f_rxg, f_acc, f_drop;

  logic               s1_valid;
  logic               s1_txv, s1_rxg, s1_acc, s1_drop, s1_irq;
  logic [LEVEL_W-1:0] s1_tx_lvl, s1_rx_lvl;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign acc      = in_valid && in_ready;

  always_comb begin
    tx_ctl   = '0;
    rx_ctl   = '0;
    irq_next = irq_on;
    f_txv    = 1'b0;
    f_rxg    = 1'b0;
    f_acc    = 1'b0;
    f_drop   = 1'b0;
    if (acc) begin
      case (func)
        FN_TX_PUSH: begin
          tx_ctl.push = !tx_stat.full;
          f_acc       = !tx_stat.full;
          if (!tx_stat.full) begin
            irq_next = 1'b1;
          end
        end
        FN_TX_POP: begin
          tx_ctl.pop = !tx_stat.empty;
          f_txv      = !tx_stat.empty;
          // The buffer ends up empty when it held one byte or none.
          if (tx_stat.low) begin
            irq_next = 1'b0;
          end
        end
        FN_RX_PUSH: begin
          rx_ctl.push = 1'b1;
          f_drop      = rx_stat.full;
        end
        FN_RX_POP: begin
          rx_ctl.pop = !rx_stat.empty;
          f_rxg      = !rx_stat.empty;
        end
        FN_RX_FLUSH: rx_ctl.flush = 1'b1;
        FN_TX_FLUSH: tx_ctl.flush = 1'b1;
        default: ;
      endcase
    end
  end

  uxr_ring #(.DEPTH(DEPTH)) u_tx_ring (
    .clk        (clk),
    .rst        (rst),
    .ctl        (tx_ctl),
    .wr_data    (data_byte),
    .rd_data    (tx_rd),
    .stat       (tx_stat),
    .level_next (tx_lvl_next)
  );

  uxr_ring #(.DEPTH(DEPTH)) u_rx_ring (
    .clk        (clk),
    .rst        (rst),
    .ctl        (rx_ctl),
    .wr_data    (data_byte),
    .rd_data    (rx_rd),
    .stat       (rx_stat),
    .level_next (rx_lvl_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_on    <= 1'b0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      irq_on <= irq_next;
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_txv    <= f_txv;
      s1_rxg    <= f_rxg;
      s1_acc    <= f_acc;
      s1_drop   <= f_drop;
      s1_irq    <= irq_next;
      s1_tx_lvl <= tx_lvl_next;
      s1_rx_lvl <= rx_lvl_next;
    end
    if (s1_adv) begin
      tx_out_valid      <= s1_txv;
      tx_out_byte       <= s1_txv ? tx_rd : '0;
      rx_got            <= s1_rxg;
      rx_out_byte       <= s1_rxg ? rx_rd : '0;
      push_accepted     <= s1_acc;
      rx_dropped_oldest <= s1_drop;
      tx_irq_enable     <= s1_irq;
      tx_level          <= s1_tx_lvl;
      rx_level          <= s1_rx_lvl;
    end
  end

`ifndef SYNTHESIS
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({tx_out_valid, rx_got, push_accepted, rx_dropped_oldest}) <= 1)
    else $error("more than one operation flag set in a result word");

  a_push_irq: assert property (@(posedge clk) disable iff (rst)
    (acc && func == FN_TX_PUSH && !tx_stat.full) |=> irq_on)
    else $error("stored transmit byte did not set the interrupt enable");

  a_ring_stat: assert property (@(posedge clk) disable iff (rst)
    !(tx_stat.full && tx_stat.empty) && !(rx_stat.full && rx_stat.empty))
    else $error("ring reports full and empty at once");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled without a full pipeline");
`endif

endmodule
